// ===== sv/assert_macros.svh =====
// Assertion helpers included by the engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/iprq_pkg.sv =====
package iprq_pkg;

  localparam int MaxNodes = 1024;
  localparam int MaxEdges = 4096;
  localparam int MaxDims  = 8;

  localparam int NodeW  = $clog2(MaxNodes);
  localparam int EdgeW  = $clog2(MaxEdges);
  localparam int DimW   = $clog2(MaxDims);
  localparam int LabW   = 12;
  localparam int LenW   = 11;
  localparam int LvlW   = 10;
  localparam int StampW = 16;
  localparam int CntW   = 11;
  localparam int SpW    = NodeW + 1;

  typedef enum logic [1:0] {
    KIND_LABEL = 2'd0,
    KIND_NODE  = 2'd1,
    KIND_EDGE  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    DEC_SAME     = 3'd0,
    DEC_INTERVAL = 3'd1,
    DEC_LEVEL    = 3'd2,
    DEC_CUT      = 3'd3,
    DEC_FOUND    = 3'd4,
    DEC_EXHAUST  = 3'd5
  } dec_t;

  typedef enum logic [1:0] {
    REG_DIMS  = 2'd0,
    REG_LEVEL = 2'd1,
    REG_CUT   = 2'd2
  } reg_idx_t;

  // Result of a containment test
  typedef enum logic [1:0] {
    TST_REJECT = 2'd0,
    TST_PASS   = 2'd1,
    TST_ACCEPT = 2'd2
  } tst_t;

  typedef struct packed {
    logic [3:0] dims;
    logic       level_on;
    logic       cut_on;
  } cfg_t;

endpackage

// ===== sv/iprq_cfg.sv =====
module iprq_cfg
  import iprq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [3:0] dims_r;
  logic       level_r;
  logic       cut_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Write registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= 4'd2;
      level_r <= 1'b0;
      cut_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DIMS:  dims_r  <= pwdata[3:0];
        REG_LEVEL: level_r <= pwdata[0];
        REG_CUT:   cut_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_DIMS:  prdata = {28'd0, dims_r};
      REG_LEVEL: prdata = {31'd0, level_r};
      REG_CUT:   prdata = {31'd0, cut_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg.dims     = dims_r;
  assign cfg.level_on = level_r;
  assign cfg.cut_on   = cut_r;

endmodule

// ===== sv/iprq_engine.sv =====
module iprq_engine
  import iprq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [NodeW-1:0] in_node,
  input  logic [NodeW-1:0] in_target_node,
  input  logic [2:0]       in_dim_index,
  input  logic [LabW-1:0]  in_pre_label,
  input  logic [LabW-1:0]  in_post_label,
  input  logic [LabW-1:0]  in_middle_label,
  input  logic [EdgeW-1:0] in_edge_offset,
  input  logic [LenW-1:0]  in_edge_count,
  input  logic [LvlW-1:0]  in_top_level,
  input  logic [EdgeW-1:0] in_edge_slot,
  output logic             out_valid,
  output logic             out_reachable,
  output logic [2:0]       out_decided_by,
  output logic [CntW-1:0]  out_nodes_expanded
);

  `include "assert_macros.svh"

  localparam int LabAw = NodeW + DimW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_TLVL, S_SLVL, S_LAB, S_LABCHK, S_PUSH,
    S_TOP, S_EDGE, S_CHILD, S_CLAB, S_CLABCHK, S_CLVL, S_DONE
  } state_t;

  // Memories
  logic [LabW-1:0]   pre_mem   [MaxNodes*MaxDims];
  logic [LabW-1:0]   post_mem  [MaxNodes*MaxDims];
  logic [LabW-1:0]   mid_mem   [MaxNodes*MaxDims];
  logic [EdgeW-1:0]  base_mem  [MaxNodes];
  logic [LenW-1:0]   len_mem   [MaxNodes];
  logic [LvlW-1:0]   lvl_mem   [MaxNodes];
  logic [NodeW-1:0]  edge_mem  [MaxEdges];
  logic [StampW-1:0] visit_mem [MaxNodes];
  logic [NodeW-1:0]  stk_node  [MaxNodes];
  logic [LenW-1:0]   stk_pos   [MaxNodes];

  state_t            state_r;
  logic [StampW-1:0] stamp_r;
  logic [NodeW-1:0]  src_r, tgt_r, cur_r, child_r, clr_r;
  logic [LenW-1:0]   pos_r;
  logic [SpW-1:0]    sp_r;
  logic [DimW-1:0]   dim_r;
  logic [CntW-1:0]   exp_r;
  logic [LvlW-1:0]   tlvl_r;
  logic              stamp_wr_r;

  // Registered read data
  logic [LabW-1:0]   a_pre_q, a_post_q, a_mid_q, t_pre_q, t_post_q;
  logic [EdgeW-1:0]  base_q;
  logic [LenW-1:0]   len_q;
  logic [LvlW-1:0]   lvl_q;
  logic [NodeW-1:0]  edge_q;
  logic [StampW-1:0] visit_q;
  logic [NodeW-1:0]  stk_node_q;
  logic [LenW-1:0]   stk_pos_q;

  logic [LabAw-1:0]  a_addr, t_addr;
  logic [NodeW-1:0]  node_raddr, visit_raddr, lab_node;
  logic [EdgeW-1:0]  edge_raddr;
  logic [NodeW-1:0]  stk_raddr;
  logic              accept, is_load;
  logic [3:0]        dims_sat;
  logic              last_dim, lab_rej, lab_acc;
  logic              lab_phase;

  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign is_load = accept && (in_kind != KIND_QUERY);

  assign dims_sat = (cfg.dims == 4'd0) ? 4'd1 :
                    (cfg.dims > 4'(MaxDims)) ? 4'(MaxDims) : cfg.dims;
  assign last_dim = ({1'b0, dim_r} + 4'd1) >= dims_sat;

  // Label-read addresses follow the node under test
  assign lab_phase = (state_r == S_LAB) || (state_r == S_LABCHK);
  assign lab_node  = lab_phase ? src_r : child_r;
  assign a_addr    = {lab_node, dim_r};
  assign t_addr    = {tgt_r, dim_r};
  assign node_raddr  = (state_r == S_TLVL) ? tgt_r :
                       (state_r == S_SLVL || lab_phase) ? src_r :
                       (state_r == S_CHILD || state_r == S_CLAB ||
                        state_r == S_CLABCHK) ? child_r : cur_r;
  assign edge_raddr  = EdgeW'(base_q + EdgeW'(pos_r));
  assign visit_raddr = child_r;
  assign stk_raddr   = NodeW'(sp_r - SpW'(1));

  // Label compare of the current dimension
  assign lab_rej = (a_pre_q > t_pre_q) || (a_post_q < t_post_q);
  assign lab_acc = cfg.cut_on && (a_mid_q < t_post_q);

  // Label stores
  always_ff @(posedge clk) begin
    if (is_load && in_kind == KIND_LABEL) begin
      pre_mem[{in_node, in_dim_index}]  <= in_pre_label;
      post_mem[{in_node, in_dim_index}] <= in_post_label;
      mid_mem[{in_node, in_dim_index}]  <= in_middle_label;
    end
    a_pre_q  <= pre_mem[a_addr];
    a_post_q <= post_mem[a_addr];
    a_mid_q  <= mid_mem[a_addr];
    t_pre_q  <= pre_mem[t_addr];
    t_post_q <= post_mem[t_addr];
  end

  // Node records
  always_ff @(posedge clk) begin
    if (is_load && in_kind == KIND_NODE) begin
      base_mem[in_node] <= in_edge_offset;
      len_mem[in_node]  <= in_edge_count;
      lvl_mem[in_node]  <= in_top_level;
    end
    base_q <= base_mem[node_raddr];
    len_q  <= len_mem[node_raddr];
    lvl_q  <= lvl_mem[node_raddr];
  end

  // Edge store
  always_ff @(posedge clk) begin
    if (is_load && in_kind == KIND_EDGE) edge_mem[in_edge_slot] <= in_target_node;
    edge_q <= edge_mem[edge_raddr];
  end

  // Visit stamps: sweep clear, or stamp write
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) visit_mem[clr_r] <= '0;
    else if (stamp_wr_r) visit_mem[child_r] <= stamp_r;
    visit_q <= visit_mem[visit_raddr];
  end

  // Search stack: push new frame or update the top position
  always_ff @(posedge clk) begin
    if (state_r == S_PUSH) begin
      stk_node[sp_r[NodeW-1:0]] <= child_r;
      stk_pos[sp_r[NodeW-1:0]]  <= '0;
    end else if (state_r == S_CHILD) begin
      stk_pos[stk_raddr] <= pos_r + LenW'(1);
    end
    stk_node_q <= stk_node[stk_raddr];
    stk_pos_q  <= stk_pos[stk_raddr];
  end

  // Query sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      stamp_r    <= '0;
      clr_r      <= '0;
      out_valid  <= 1'b0;
      stamp_wr_r <= 1'b0;
      sp_r       <= '0;
    end else begin
      out_valid  <= 1'b0;
      stamp_wr_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + NodeW'(1);
          if (clr_r == NodeW'(MaxNodes - 1)) begin
            // After a stamp wrap, resume with the source push
            state_r    <= (stamp_r == '0) ? S_IDLE : S_PUSH;
            stamp_wr_r <= (stamp_r != '0);
          end
        end
        S_IDLE: begin
          if (accept && in_kind == KIND_QUERY) begin
            src_r   <= in_node;
            tgt_r   <= in_target_node;
            child_r <= in_node;
            cur_r   <= in_node;
            dim_r   <= '0;
            exp_r   <= '0;
            if (in_node == in_target_node) begin
              out_valid          <= 1'b1;
              out_reachable      <= 1'b1;
              out_decided_by     <= DEC_SAME;
              out_nodes_expanded <= '0;
            end else begin
              state_r <= S_TLVL;
            end
          end
        end
        S_TLVL: state_r <= S_SLVL;
        S_SLVL: begin
          tlvl_r  <= lvl_q;
          state_r <= S_LAB;
        end
        S_LAB: state_r <= S_LABCHK;
        S_LABCHK: begin
          // lvl_q holds the source level here
          if (cfg.level_on && cfg.cut_on && lvl_q >= tlvl_r) begin
            out_valid <= 1'b1; out_reachable <= 1'b0;
            out_decided_by <= DEC_LEVEL; out_nodes_expanded <= '0;
            state_r <= S_IDLE;
          end else if (lab_rej) begin
            out_valid <= 1'b1; out_reachable <= 1'b0;
            out_decided_by <= DEC_INTERVAL; out_nodes_expanded <= '0;
            state_r <= S_IDLE;
          end else if (lab_acc) begin
            out_valid <= 1'b1; out_reachable <= 1'b1;
            out_decided_by <= DEC_CUT; out_nodes_expanded <= '0;
            state_r <= S_IDLE;
          end else if (!last_dim) begin
            dim_r   <= dim_r + DimW'(1);
            state_r <= S_LAB;
          end else if (cfg.level_on && lvl_q >= tlvl_r) begin
            out_valid <= 1'b1; out_reachable <= 1'b0;
            out_decided_by <= DEC_LEVEL; out_nodes_expanded <= '0;
            state_r <= S_IDLE;
          end else begin
            // New stamp; a wrap clears the visit store first
            if (stamp_r == {StampW{1'b1}}) begin
              stamp_r <= StampW'(1);
              clr_r   <= '0;
              state_r <= S_CLEAR;
            end else begin
              stamp_r <= stamp_r + StampW'(1);
              state_r <= S_PUSH;
            end
            stamp_wr_r <= (stamp_r != {StampW{1'b1}});
            child_r    <= src_r;
            sp_r       <= '0;
          end
        end
        S_PUSH: begin
          sp_r    <= sp_r + SpW'(1);
          exp_r   <= exp_r + CntW'(1);
          state_r <= S_TOP;
        end
        S_TOP: state_r <= S_EDGE;
        S_EDGE: begin
          // stack top and node record of that node
          if (sp_r == '0) begin
            out_valid <= 1'b1; out_reachable <= 1'b0;
            out_decided_by <= DEC_EXHAUST; out_nodes_expanded <= exp_r;
            state_r <= S_IDLE;
          end else if (cur_r != stk_node_q) begin
            cur_r   <= stk_node_q;
            state_r <= S_TOP;
          end else if (stk_pos_q >= len_q) begin
            sp_r    <= sp_r - SpW'(1);
            state_r <= S_TOP;
          end else begin
            pos_r   <= stk_pos_q;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // edge read issued on base_q + pos_r
          state_r <= S_CHILD;
        end
        S_CHILD: begin
          child_r <= edge_q;
          dim_r   <= '0;
          state_r <= S_CLAB;
        end
        S_CLAB: state_r <= S_CLABCHK;
        S_CLABCHK: begin
          if (visit_q == stamp_r || lab_rej) begin
            state_r <= S_TOP;
          end else if (lab_acc) begin
            out_valid <= 1'b1; out_reachable <= 1'b1;
            out_decided_by <= DEC_CUT; out_nodes_expanded <= exp_r;
            state_r <= S_IDLE;
          end else if (!last_dim) begin
            dim_r   <= dim_r + DimW'(1);
            state_r <= S_CLAB;
          end else if (child_r == tgt_r) begin
            out_valid <= 1'b1; out_reachable <= 1'b1;
            out_decided_by <= DEC_FOUND; out_nodes_expanded <= exp_r;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CLVL;
          end
        end
        S_CLVL: begin
          if (cfg.level_on && lvl_q >= tlvl_r) begin
            state_r <= S_TOP;
          end else if (sp_r == SpW'(MaxNodes)) begin
            stamp_wr_r <= 1'b1;
            exp_r      <= exp_r + CntW'(1);
            state_r    <= S_TOP;
          end else begin
            stamp_wr_r <= 1'b1;
            state_r    <= S_PUSH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_busy_no_load, clk, rst_n, busy, !is_load, "load taken while busy")
  `ASSERT_IMPLIES(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")
  `ASSERT_IMPLIES(a_sp_range, clk, rst_n, 1'b1, sp_r <= SpW'(MaxNodes), "stack overflow")

endmodule

// ===== sv/interval_pruned_reach_query_top.sv =====
// Channel   Handshake            Fields
// in        start / busy         in_kind .. in_edge_slot
// out       out_valid strobe     out_reachable, out_decided_by, out_nodes_expanded
// cfg       APB psel/penable     3 registers at 0x0, 0x4, 0x8
// Loads and same-node queries are taken without leaving idle. Other queries read
// the target and source levels, then compare the source labels one dimension at
// a time. Each child edge is read from the stack top and node record, its labels
// are compared per dimension, a child that passes is entered, and a finished
// node is popped. After reset, and on stamp wrap, the visit store is swept while
// busy stays high. The result strobe lasts one cycle; the receiver cannot stall.
module interval_pruned_reach_query_top
  import iprq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [NodeW-1:0] in_node,
  input  logic [NodeW-1:0] in_target_node,
  input  logic [2:0]       in_dim_index,
  input  logic [LabW-1:0]  in_pre_label,
  input  logic [LabW-1:0]  in_post_label,
  input  logic [LabW-1:0]  in_middle_label,
  input  logic [EdgeW-1:0] in_edge_offset,
  input  logic [LenW-1:0]  in_edge_count,
  input  logic [LvlW-1:0]  in_top_level,
  input  logic [EdgeW-1:0] in_edge_slot,
  output logic             out_valid,
  output logic             out_reachable,
  output logic [2:0]       out_decided_by,
  output logic [CntW-1:0]  out_nodes_expanded
);

  cfg_t cfg;

  iprq_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  iprq_engine u_eng (
    .clk, .rst_n, .cfg, .start, .busy, .in_kind, .in_node, .in_target_node,
    .in_dim_index, .in_pre_label, .in_post_label, .in_middle_label,
    .in_edge_offset, .in_edge_count, .in_top_level, .in_edge_slot,
    .out_valid, .out_reachable, .out_decided_by, .out_nodes_expanded
  );

endmodule
